>>> design/vmx_pkg.sv
// shared types, codes and helper functions for the valve mixer
package vmx_pkg;

  localparam int DutyW   = 8;
  localparam int PDestW  = 12;
  localparam int DepthW  = 15;
  localparam int ErrW    = 15;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PITCH_DZ    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PITCH_SHIFT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_DZ    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_SHIFT = 2'd3;

  localparam logic [6:0] PITCH_DZ_RST    = 7'd5;
  localparam logic [3:0] PITCH_SHIFT_RST = 4'd3;
  localparam logic [7:0] DEPTH_DZ_RST    = 8'd20;
  localparam logic [3:0] DEPTH_SHIFT_RST = 4'd3;

  localparam logic [7:0] LR_MASK = 8'hCC;
  localparam logic [7:0] UD_MASK = 8'h33;

  // left/right codes, named after the valves they open
  localparam logic [7:0] LR_HR_TL = 8'h04;
  localparam logic [7:0] LR_HL_TR = 8'h08;
  localparam logic [7:0] LR_HR_TR = 8'h40;
  localparam logic [7:0] LR_HL_TL = 8'h80;
  localparam logic [7:0] LR_HR    = 8'h44;
  localparam logic [7:0] LR_HL    = 8'h88;
  localparam logic [7:0] LR_TR    = 8'h48;
  localparam logic [7:0] LR_TL    = 8'h84;

  // up/down codes
  localparam logic [7:0] UD_HD_TU = 8'h01;
  localparam logic [7:0] UD_HU_TD = 8'h02;
  localparam logic [7:0] UD_HD_TD = 8'h10;
  localparam logic [7:0] UD_HU_TU = 8'h20;
  localparam logic [7:0] UD_HD    = 8'h11;
  localparam logic [7:0] UD_HU    = 8'h22;
  localparam logic [7:0] UD_TD    = 8'h12;
  localparam logic [7:0] UD_TU    = 8'h21;

  localparam logic [DutyW-1:0] DUTY_ON  = 8'hFF;
  localparam logic [DutyW-1:0] DUTY_OFF = 8'h00;

  localparam logic [10:0] PITCH_WRAP_LIM = 11'd180;
  localparam logic [11:0] PITCH_WRAP     = 12'd360;

  typedef struct packed {
    logic [DutyW-1:0] hd;
    logic [DutyW-1:0] hr;
    logic [DutyW-1:0] td;
    logic [DutyW-1:0] tr;
    logic [DutyW-1:0] tl;
    logic [DutyW-1:0] tu;
    logic [DutyW-1:0] fw;
    logic [DutyW-1:0] hu;
    logic [DutyW-1:0] hl;
    logic [DutyW-1:0] bw;
  } duty_t;

  typedef struct packed {
    logic [6:0] pitch_dz;
    logic [3:0] pitch_shift;
    logic [7:0] depth_dz;
    logic [3:0] depth_shift;
  } cfg_t;

  // after decode
  typedef struct packed {
    duty_t             duty;
    logic              ph;
    logic              dh;
    logic [PDestW-1:0] pitch_goal;
    logic [7:0]        pitch_now;
    logic [DepthW-1:0] depth_now;
    logic [DepthW-1:0] depth_goal;
  } dec_t;

  // after error stage
  typedef struct packed {
    duty_t           duty;
    logic            ph;
    logic            dh;
    logic            p_up;
    logic [ErrW-1:0] p_err;
    logic            d_down;
    logic [ErrW-1:0] d_err;
  } err_t;

  typedef struct packed {
    logic             act;
    logic [DutyW-1:0] duty;
  } hold_t;

  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return 8'(hi * 8'd10) + {4'd0, b[3:0]};
  endfunction

  // proportional duty beyond the deadzone, saturated at full on
  function automatic hold_t hold_duty(input logic [ErrW-1:0] err,
                                      input logic [7:0] dz,
                                      input logic [3:0] shift);
    hold_t           r;
    logic [ErrW-1:0] over;
    logic [8:0]      lim;
    logic [16:0]     prod;
    over   = err - {7'd0, dz};
    lim    = 9'd256 >> shift;
    prod   = {8'd0, over[8:0]} << shift;
    r.act  = err > {7'd0, dz};
    if (over > {6'd0, lim}) begin
      r.duty = DUTY_ON;
    end else if (prod > 17'd255) begin
      r.duty = DUTY_ON;
    end else begin
      r.duty = prod[7:0];
    end
    return r;
  endfunction

endpackage

>>> design/vmx_decode.sv
// stage 1: thrust and steering decode and bcd to binary conversion
module vmx_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [2:0]    thrust_bits_i,
  input  logic [7:0]    steer_bits_i,
  input  logic          pitch_hold_on_i,
  input  logic          depth_hold_on_i,
  input  logic [15:0]   pitch_target_bcd_i,
  input  logic [15:0]   depth_target_bcd_i,
  input  logic [15:0]   depth_now_bcd_i,
  input  logic [7:0]    pitch_now_i,
  output logic          valid_o,
  input  logic          ready_i,
  output vmx_pkg::dec_t data_o
);
  import vmx_pkg::*;

  logic       valid_q;
  dec_t       data_q, data_d;
  logic [7:0] lr, ud;
  logic [10:0] pdest;

  assign ready_o = !valid_q || ready_i;
  assign lr = steer_bits_i & LR_MASK;
  assign ud = steer_bits_i & UD_MASK;

  always_comb begin
    data_d = '0;
    data_d.duty.fw = (|thrust_bits_i[2:1]) ? DUTY_ON : DUTY_OFF;
    data_d.duty.bw = thrust_bits_i[0] ? DUTY_ON : DUTY_OFF;
    case (lr)
      LR_HR_TL: begin data_d.duty.hr = DUTY_ON; data_d.duty.tl = DUTY_ON; end
      LR_HL_TR: begin data_d.duty.hl = DUTY_ON; data_d.duty.tr = DUTY_ON; end
      LR_HR_TR: begin data_d.duty.hr = DUTY_ON; data_d.duty.tr = DUTY_ON; end
      LR_HL_TL: begin data_d.duty.hl = DUTY_ON; data_d.duty.tl = DUTY_ON; end
      LR_HR:    data_d.duty.hr = DUTY_ON;
      LR_HL:    data_d.duty.hl = DUTY_ON;
      LR_TR:    data_d.duty.tr = DUTY_ON;
      LR_TL:    data_d.duty.tl = DUTY_ON;
      default: ;
    endcase
    case (ud)
      UD_HD_TU: begin data_d.duty.hd = DUTY_ON; data_d.duty.tu = DUTY_ON; end
      UD_HU_TD: begin data_d.duty.hu = DUTY_ON; data_d.duty.td = DUTY_ON; end
      UD_HD_TD: begin data_d.duty.hd = DUTY_ON; data_d.duty.td = DUTY_ON; end
      UD_HU_TU: begin data_d.duty.hu = DUTY_ON; data_d.duty.tu = DUTY_ON; end
      UD_HD:    data_d.duty.hd = DUTY_ON;
      UD_HU:    data_d.duty.hu = DUTY_ON;
      UD_TD:    data_d.duty.td = DUTY_ON;
      UD_TU:    data_d.duty.tu = DUTY_ON;
      default: ;
    endcase
    data_d.ph = pitch_hold_on_i;
    data_d.dh = depth_hold_on_i;
    // targets above 180 degrees wrap to negative
    pdest = 11'({3'd0, bcd_byte(pitch_target_bcd_i[15:8])} * 11'd10)
            + {7'd0, pitch_target_bcd_i[7:4]};
    data_d.pitch_goal = (pdest > PITCH_WRAP_LIM) ? ({1'b0, pdest} - PITCH_WRAP)
                                                  : {1'b0, pdest};
    data_d.pitch_now  = pitch_now_i;
    data_d.depth_now  = 15'({7'd0, bcd_byte(depth_now_bcd_i[15:8])} * 15'd100)
                        + {7'd0, bcd_byte(depth_now_bcd_i[7:0])};
    data_d.depth_goal = 15'({7'd0, bcd_byte(depth_target_bcd_i[15:8])} * 15'd100)
                        + {7'd0, bcd_byte(depth_target_bcd_i[7:0])};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/vmx_error.sv
// stage 2: pitch and depth error magnitudes with direction flags
module vmx_error (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  vmx_pkg::dec_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output vmx_pkg::err_t data_o
);
  import vmx_pkg::*;

  logic        valid_q;
  err_t        data_q, data_d;
  logic [12:0] pdiff, pmag;
  logic [15:0] ddiff, dmag;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    pdiff = {data_i.pitch_goal[PDestW-1], data_i.pitch_goal}
            - {{5{data_i.pitch_now[7]}}, data_i.pitch_now};
    pmag  = pdiff[12] ? (13'd0 - pdiff) : pdiff;
    ddiff = {1'b0, data_i.depth_goal} - {1'b0, data_i.depth_now};
    dmag  = ddiff[15] ? (16'd0 - ddiff) : ddiff;
    data_d.duty   = data_i.duty;
    data_d.ph     = data_i.ph;
    data_d.dh     = data_i.dh;
    data_d.p_up   = !pdiff[12] && (|pdiff);
    data_d.p_err  = {3'd0, pmag[11:0]};
    data_d.d_down = !ddiff[15] && (|ddiff);
    data_d.d_err  = dmag[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/vmx_hold.sv
// stage 3: pitch hold then depth hold override of the vertical valves
module vmx_hold (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vmx_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  vmx_pkg::err_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output vmx_pkg::duty_t data_o
);
  import vmx_pkg::*;

  logic  valid_q;
  duty_t data_q, data_d;
  hold_t ph_r, dh_r;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ph_r   = hold_duty(data_i.p_err, {1'b0, cfg_i.pitch_dz}, cfg_i.pitch_shift);
    dh_r   = hold_duty(data_i.d_err, cfg_i.depth_dz, cfg_i.depth_shift);
    data_d = data_i.duty;
    if (data_i.ph && ph_r.act) begin
      data_d.hu = data_i.p_up ? ph_r.duty : DUTY_OFF;
      data_d.td = data_i.p_up ? ph_r.duty : DUTY_OFF;
      data_d.hd = data_i.p_up ? DUTY_OFF : ph_r.duty;
      data_d.tu = data_i.p_up ? DUTY_OFF : ph_r.duty;
    end
    // depth wins over pitch
    if (data_i.dh && dh_r.act) begin
      data_d.hd = data_i.d_down ? dh_r.duty : DUTY_OFF;
      data_d.td = data_i.d_down ? dh_r.duty : DUTY_OFF;
      data_d.hu = data_i.d_down ? DUTY_OFF : dh_r.duty;
      data_d.tu = data_i.d_down ? DUTY_OFF : dh_r.duty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/vmx_sum.sv
// stage 4: frame checksum and output register
module vmx_sum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  vmx_pkg::duty_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output vmx_pkg::duty_t duty_o,
  output logic [7:0]     sum_o
);
  import vmx_pkg::*;

  logic       valid_q;
  duty_t      duty_q;
  logic [7:0] sum_q, sum_d, acc;

  assign ready_o = !valid_q || ready_i;

  // checksum is the two's complement of the sum of all ten duties, modulo 256
  always_comb begin
    acc = ((data_i.hd + data_i.hr) + (data_i.td + data_i.tr))
        + ((data_i.tl + data_i.tu) + (data_i.fw + data_i.hu))
        + (data_i.hl + data_i.bw);
    sum_d = 8'd0 - acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      duty_q <= data_i;
      sum_q  <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign duty_o  = duty_q;
  assign sum_o   = sum_q;

endmodule

>>> design/valve_mixer_with_depth_pitch_hold.sv
// valve mixer top level: config registers and the four-stage pipeline
// Usage:
// One control frame enters on the input channel (in_valid_i / in_stall_o)
// and one transaction of ten valve duties plus the frame checksum leaves
// on the output channel (out_valid_o / out_stall_i).
// A transaction is taken at a clock edge where valid is high and stall low.
// A frame passes through decode, error, hold override and checksum,
// each closed by a register stage.
// Throughput is one frame per cycle while out_stall_i is low; each stage
// moves whenever its successor is empty or moving, squeezing out bubbles.
// When the receiver stalls, the output holds its payload and the stages
// behind it fill up; in_stall_o rises only once all four stages are full.
// Reset clears all valid bits and loads the hold registers with their
// defaults (pitch deadzone 5, depth deadzone 20, both gain shifts 3).
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect on
// the next edge and are expected only while the pipeline is empty.
module valve_mixer_with_depth_pitch_hold (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vmx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vmx_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  thrust_bits_i,
  input  logic [7:0]                  steer_bits_i,
  input  logic                        pitch_hold_on_i,
  input  logic                        depth_hold_on_i,
  input  logic [15:0]                 pitch_target_bcd_i,
  input  logic [15:0]                 depth_target_bcd_i,
  input  logic [15:0]                 depth_now_bcd_i,
  input  logic signed [7:0]           pitch_now_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  duty_head_down_o,
  output logic [7:0]                  duty_head_right_o,
  output logic [7:0]                  duty_tail_down_o,
  output logic [7:0]                  duty_tail_right_o,
  output logic [7:0]                  duty_tail_left_o,
  output logic [7:0]                  duty_tail_up_o,
  output logic [7:0]                  duty_forward_o,
  output logic [7:0]                  duty_head_up_o,
  output logic [7:0]                  duty_head_left_o,
  output logic [7:0]                  duty_backward_o,
  output logic [7:0]                  frame_sum_o
);
  import vmx_pkg::*;

  cfg_t  cfg_q;
  logic  s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready, s4_ready;
  dec_t  s1_data;
  err_t  s2_data;
  duty_t s3_data, out_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_dz    <= PITCH_DZ_RST;
      cfg_q.pitch_shift <= PITCH_SHIFT_RST;
      cfg_q.depth_dz    <= DEPTH_DZ_RST;
      cfg_q.depth_shift <= DEPTH_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PITCH_DZ:    cfg_q.pitch_dz    <= cfg_data_i[6:0];
        CFG_PITCH_SHIFT: cfg_q.pitch_shift <= cfg_data_i[3:0];
        CFG_DEPTH_DZ:    cfg_q.depth_dz    <= cfg_data_i[7:0];
        CFG_DEPTH_SHIFT: cfg_q.depth_shift <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic s1_in_ready;
  assign in_stall_o = !s1_in_ready;

  vmx_decode u_decode (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid_i),
    .ready_o            (s1_in_ready),
    .thrust_bits_i      (thrust_bits_i),
    .steer_bits_i       (steer_bits_i),
    .pitch_hold_on_i    (pitch_hold_on_i),
    .depth_hold_on_i    (depth_hold_on_i),
    .pitch_target_bcd_i (pitch_target_bcd_i),
    .depth_target_bcd_i (depth_target_bcd_i),
    .depth_now_bcd_i    (depth_now_bcd_i),
    .pitch_now_i        (pitch_now_i),
    .valid_o            (s1_valid),
    .ready_i            (s1_ready),
    .data_o             (s1_data)
  );

  vmx_error u_error (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  vmx_hold u_hold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  assign s4_ready = !out_stall_i;

  vmx_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .data_i  (s3_data),
    .valid_o (out_valid_o),
    .ready_i (s4_ready),
    .duty_o  (out_duty),
    .sum_o   (frame_sum_o)
  );

  assign duty_head_down_o  = out_duty.hd;
  assign duty_head_right_o = out_duty.hr;
  assign duty_tail_down_o  = out_duty.td;
  assign duty_tail_right_o = out_duty.tr;
  assign duty_tail_left_o  = out_duty.tl;
  assign duty_tail_up_o    = out_duty.tu;
  assign duty_forward_o    = out_duty.fw;
  assign duty_head_up_o    = out_duty.hu;
  assign duty_head_left_o  = out_duty.hl;
  assign duty_backward_o   = out_duty.bw;

endmodule
